>>> hdl/two_list_sorted_merge_defines.svh
// Assertion macros for the two-list sorted merge block.
// Used by the top level; relies on a clock named clk and a reset named rst_n.
`ifndef TWO_LIST_SORTED_MERGE_DEFINES_SVH
`define TWO_LIST_SORTED_MERGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tlsm_pkg.sv
// Package for the two-list sorted merge block.
// Holds list depth, derived widths, codes and the list memory request type.
`default_nettype none

package tlsm_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int VALUE_W    = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [IDX_W-1:0]          idx_t;

  typedef enum logic [1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_MERGE  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    idx_t   raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hdl/tlsm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module tlsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/tlsm_ctrl.sv
// Command decoder, list fill counters and merge sequencer with output register.
// Depends on tlsm_pkg; drives the two list memories through mem_req_t.
`default_nettype none

module tlsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire tlsm_pkg::value_t  in_value,
  output tlsm_pkg::mem_req_t     req_a,
  output tlsm_pkg::mem_req_t     req_b,
  input  wire tlsm_pkg::value_t  rdata_a,
  input  wire tlsm_pkg::value_t  rdata_b,
  output logic                   out_valid,
  output tlsm_pkg::value_t       out_merged_value,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  tlsm_pkg::state_t  state_r, state_nxt;
  tlsm_pkg::cnt_t    cnt_a_r, cnt_a_nxt;
  tlsm_pkg::cnt_t    cnt_b_r, cnt_b_nxt;
  tlsm_pkg::cnt_t    i_r, i_nxt;
  tlsm_pkg::cnt_t    j_r, j_nxt;
  logic              ovf_r, ovf_nxt;
  logic              valid_r, valid_nxt;
  tlsm_pkg::value_t  value_r, value_nxt;
  tlsm_pkg::status_t status_r, status_nxt;
  logic              last_r, last_nxt;
  logic              take_a;
  logic              full_a, full_b;
  tlsm_pkg::opcode_t op;

  assign op     = tlsm_pkg::opcode_t'(in_opcode);
  assign full_a = (cnt_a_r == tlsm_pkg::CNT_W'(tlsm_pkg::LIST_DEPTH));
  assign full_b = (cnt_b_r == tlsm_pkg::CNT_W'(tlsm_pkg::LIST_DEPTH));
  assign take_a = (i_r < cnt_a_r) &&
                  ((j_r >= cnt_b_r) || (rdata_a < rdata_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlsm_pkg::S_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      ovf_r   <= ovf_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ovf_nxt    = ovf_r;
    valid_nxt  = 1'b0;
    value_nxt  = '0;
    status_nxt = tlsm_pkg::ST_DATA;
    last_nxt   = 1'b0;
    req_a      = '0;
    req_b      = '0;
    req_a.waddr = cnt_a_r[tlsm_pkg::IDX_W-1:0];
    req_b.waddr = cnt_b_r[tlsm_pkg::IDX_W-1:0];
    req_a.wdata = in_value;
    req_b.wdata = in_value;
    unique case (state_r)
      tlsm_pkg::S_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        if (start) begin
          unique case (op)
            tlsm_pkg::OP_PUSH_A: begin
              if (full_a) begin
                ovf_nxt = 1'b1;
              end else begin
                req_a.we  = 1'b1;
                cnt_a_nxt = cnt_a_r + 1'b1;
              end
            end
            tlsm_pkg::OP_PUSH_B: begin
              if (full_b) begin
                ovf_nxt = 1'b1;
              end else begin
                req_b.we  = 1'b1;
                cnt_b_nxt = cnt_b_r + 1'b1;
              end
            end
            tlsm_pkg::OP_MERGE: begin
              if (ovf_r || (cnt_a_r != cnt_b_r) || (cnt_a_r == '0)) begin
                valid_nxt = 1'b1;
                last_nxt  = 1'b1;
                if (ovf_r) begin
                  status_nxt = tlsm_pkg::ST_OVERFLOW;
                end else if (cnt_a_r != cnt_b_r) begin
                  status_nxt = tlsm_pkg::ST_MISMATCH;
                end else begin
                  status_nxt = tlsm_pkg::ST_EMPTY;
                end
                cnt_a_nxt = '0;
                cnt_b_nxt = '0;
                ovf_nxt   = 1'b0;
              end else begin
                state_nxt = tlsm_pkg::S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tlsm_pkg::S_RUN: begin
        valid_nxt = 1'b1;
        if (take_a) begin
          value_nxt = rdata_a;
          i_nxt     = i_r + 1'b1;
        end else begin
          value_nxt = rdata_b;
          j_nxt     = j_r + 1'b1;
        end
        if ((i_nxt == cnt_a_r) && (j_nxt == cnt_b_r)) begin
          last_nxt  = 1'b1;
          state_nxt = tlsm_pkg::S_IDLE;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = tlsm_pkg::S_IDLE;
      end
    endcase
    req_a.raddr = i_nxt[tlsm_pkg::IDX_W-1:0];
    req_b.raddr = j_nxt[tlsm_pkg::IDX_W-1:0];
  end

  assign busy             = (state_r != tlsm_pkg::S_IDLE);
  assign out_valid        = valid_r;
  assign out_merged_value = value_r;
  assign out_status       = status_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

>>> hdl/two_list_sorted_merge.sv
// Top level of the two-list sorted merge block: sequencer plus two list memories.
// Depends on tlsm_pkg, tlsm_ctrl, tlsm_ram and two_list_sorted_merge_defines.svh.
// Pushes are accepted back to back and give no result.
// A merge that ends in a status result shows it in the cycle after the command beat.
// A merge of two lists of N elements gives its first result after the registered memory
// read and the output register, then one per cycle for all 2N elements, busy while it runs.
// Synchronous reset clears counts and overflow; list contents stay undefined.
`default_nettype none
`include "two_list_sorted_merge_defines.svh"

module two_list_sorted_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire tlsm_pkg::value_t  in_value,
  output logic                   out_valid,
  output tlsm_pkg::value_t       out_merged_value,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  tlsm_pkg::mem_req_t req_a;
  tlsm_pkg::mem_req_t req_b;
  tlsm_pkg::value_t   rdata_a;
  tlsm_pkg::value_t   rdata_b;

  tlsm_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .req_a            (req_a),
    .req_b            (req_b),
    .rdata_a          (rdata_a),
    .rdata_b          (rdata_b),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  tlsm_ram #(
    .WIDTH (tlsm_pkg::VALUE_W),
    .DEPTH (tlsm_pkg::LIST_DEPTH)
  ) u_list_a (
    .clk   (clk),
    .we    (req_a.we),
    .waddr (req_a.waddr),
    .wdata (req_a.wdata),
    .raddr (req_a.raddr),
    .rdata (rdata_a)
  );

  tlsm_ram #(
    .WIDTH (tlsm_pkg::VALUE_W),
    .DEPTH (tlsm_pkg::LIST_DEPTH)
  ) u_list_b (
    .clk   (clk),
    .we    (req_b.we),
    .waddr (req_b.waddr),
    .wdata (req_b.wdata),
    .raddr (req_b.raddr),
    .rdata (rdata_b)
  );

  `TLSM_ASSERT_SAME(a_status_is_last, out_valid && (out_status != tlsm_pkg::ST_DATA), out_last && (out_merged_value == '0), "status beat must be the only one of its merge")
  `TLSM_ASSERT_SAME(a_last_frees_block, out_valid && out_last, !busy, "block still busy after the final beat")
  `TLSM_ASSERT_NEXT(a_merge_answers, start && !busy && (in_opcode == tlsm_pkg::OP_MERGE), out_valid || busy, "merge command produced no activity")

endmodule

`default_nettype wire

>>> tb/sv/tb_two_list_sorted_merge.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_list_sorted_merge: directed command table, then random lists.
// Depends on tlsm_pkg and two_list_sorted_merge; shadow lists predict all but typed rows' beats.
module tb_two_list_sorted_merge;
  import tlsm_pkg::*;

  localparam int ITEM_TARGET = 370;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_GAP     = 40;

  typedef struct {
    value_t  merged;
    status_t status;
    logic    last;
  } merge_beat_t;

  typedef struct {
    opcode_t op;
    value_t  val;
    bit      typed;
    status_t st;
  } cmd_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_opcode = OP_NONE;
  value_t     in_value = '0;
  logic       busy;
  logic       out_valid;
  value_t     out_merged_value;
  logic [1:0] out_status;
  logic       out_last;

  value_t      shadow_a [LIST_DEPTH];
  value_t      shadow_b [LIST_DEPTH];
  int          fill_a = 0;
  int          fill_b = 0;
  bit          lost_push = 1'b0;
  merge_beat_t fresh_beats[$];
  merge_beat_t merge_beats_due[$];
  cmd_row_t    directed_cmds[$];
  int          command_beats = 0;
  int          idle_pct = 33;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;

  two_list_sorted_merge i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic log_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void apply_list_command(opcode_t op, value_t val);
    int          i;
    int          j;
    merge_beat_t beat;
    fresh_beats.delete();
    case (op)
      OP_PUSH_A: begin
        if (fill_a < LIST_DEPTH) begin
          shadow_a[fill_a] = val;
          fill_a++;
        end else begin
          lost_push = 1'b1;
        end
      end
      OP_PUSH_B: begin
        if (fill_b < LIST_DEPTH) begin
          shadow_b[fill_b] = val;
          fill_b++;
        end else begin
          lost_push = 1'b1;
        end
      end
      OP_MERGE: begin
        beat = '{merged: '0, status: ST_DATA, last: 1'b1};
        if (lost_push) beat.status = ST_OVERFLOW;
        else if (fill_a != fill_b) beat.status = ST_MISMATCH;
        else if (fill_a == 0) beat.status = ST_EMPTY;
        if (beat.status != ST_DATA) begin
          fresh_beats.insert(fresh_beats.size(), beat);
        end else begin
          i = 0;
          j = 0;
          while (i < fill_a || j < fill_b) begin
            // The second list wins a tie.
            if (i < fill_a && (j >= fill_b || shadow_a[i] < shadow_b[j])) begin
              beat.merged = shadow_a[i];
              i++;
            end else begin
              beat.merged = shadow_b[j];
              j++;
            end
            beat.last = (i + j == fill_a + fill_b);
            fresh_beats.insert(fresh_beats.size(), beat);
          end
        end
        fill_a = 0;
        fill_b = 0;
        lost_push = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic issue_cmd(opcode_t op, value_t val, bit typed = 1'b0, status_t st = ST_DATA);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      in_opcode <= 2'($urandom_range(0, 3));
      in_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_value <= val;
    do @(posedge clk); while (busy);
    apply_list_command(op, val);
    if (typed) begin
      merge_beats_due.insert(merge_beats_due.size(),
                             '{merged: '0, status: st, last: 1'b1});
    end else begin
      foreach (fresh_beats[k]) merge_beats_due.insert(merge_beats_due.size(), fresh_beats[k]);
    end
    if (op != OP_NONE) command_beats++;
  endtask

  function automatic void add_row(opcode_t op, value_t val, bit typed = 1'b0,
                                  status_t st = ST_DATA);
    cmd_row_t row;
    row = '{op: op, val: val, typed: typed, st: st};
    directed_cmds.insert(directed_cmds.size(), row);
  endfunction

  function automatic longint next_up(longint prev, int rem, bit tight);
    longint room;
    if (tight) return prev + $urandom_range(0, 2);
    room = (longint'(32'h7FFF_FFFF) - prev) / rem;
    return prev + longint'(({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (room + 1));
  endfunction

  task automatic run_random_lists();
    int     seq_no;
    int     kind;
    int     r;
    int     na;
    int     nb;
    bit     raw;
    bit     tight;
    bit     to_a;
    longint pa;
    longint pb;
    longint v;
    seq_no = 0;
    while (command_beats < ITEM_TARGET) begin
      if (command_beats < ITEM_TARGET / 3) idle_pct = 33;
      else if (command_beats < 2 * ITEM_TARGET / 3) idle_pct = 82;
      else idle_pct = 0;
      if (seq_no % 7 == 3 && merge_beats_due.size() != 0) begin
        start <= 1'b0;
        while (merge_beats_due.size() != 0) @(posedge clk);
      end
      seq_no++;
      kind = $urandom_range(0, 99);
      raw = 1'b0;
      tight = ($urandom_range(0, 2) == 0);
      if (kind < 65) begin
        r = $urandom_range(0, 19);
        if (r == 0) na = LIST_DEPTH;
        else if (r < 3) na = $urandom_range(5, LIST_DEPTH - 1);
        else na = $urandom_range(1, 4);
        nb = na;
      end else if (kind < 75) begin
        raw = 1'b1;
        na = $urandom_range(0, 5);
        nb = na + $urandom_range(1, 4);
        if ($urandom_range(0, 1)) begin
          r = na;
          na = nb;
          nb = r;
        end
      end else if (kind < 83) begin
        na = LIST_DEPTH + $urandom_range(1, 2);
        nb = $urandom_range(0, LIST_DEPTH);
        if ($urandom_range(0, 1)) begin
          r = na;
          na = nb;
          nb = r;
        end
      end else if (kind < 90) begin
        na = 0;
        nb = 0;
      end else begin
        raw = 1'b1;
        na = $urandom_range(1, 6);
        nb = na;
      end
      pa = tight ? -longint'($urandom_range(2, 6)) : -longint'(64'h8000_0000);
      pb = tight ? -longint'($urandom_range(2, 6)) : -longint'(64'h8000_0000);
      while (na > 0 || nb > 0) begin
        if ($urandom_range(0, 24) == 0) issue_cmd(OP_NONE, $urandom);
        to_a = (na > 0) && (nb == 0 || $urandom_range(0, 1));
        if (to_a) begin
          v = raw ? longint'($urandom) : next_up(pa, na, tight);
          pa = v;
          na--;
          issue_cmd(OP_PUSH_A, value_t'(v[31:0]));
        end else begin
          v = raw ? longint'($urandom) : next_up(pb, nb, tight);
          pb = v;
          nb--;
          issue_cmd(OP_PUSH_B, value_t'(v[31:0]));
        end
      end
      issue_cmd(OP_MERGE, $urandom);
    end
  endtask

  always @(posedge clk) begin : check_results
    merge_beat_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (merge_beats_due.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = merge_beats_due.pop_front();
        if (out_merged_value !== want.merged)
          log_mismatch($sformatf("result %0d value got %0d want %0d", results_seen,
                                 out_merged_value, want.merged));
        if (out_status !== want.status)
          log_mismatch($sformatf("result %0d status got %0d want %0d", results_seen,
                                 out_status, want.status));
        if (out_last !== want.last)
          log_mismatch($sformatf("result %0d last got %0b want %0b", results_seen,
                                 out_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    add_row(OP_MERGE, '0, 1'b1, ST_EMPTY);
    add_row(OP_NONE, 32'hFFFF_FFFF);
    add_row(OP_PUSH_B, 32'sd7);
    add_row(OP_MERGE, '0, 1'b1, ST_MISMATCH);
    add_row(OP_PUSH_A, 32'h7FFF_FFFF);
    add_row(OP_PUSH_A, 32'h8000_0000);
    add_row(OP_PUSH_B, 32'h8000_0000);
    add_row(OP_PUSH_B, 32'h7FFF_FFFF);
    add_row(OP_MERGE, 32'hFFFF_FFFF);
    for (int k = 0; k <= LIST_DEPTH; k++) add_row(OP_PUSH_B, value_t'(k - 8));
    add_row(OP_MERGE, '0, 1'b1, ST_OVERFLOW);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_cmds[r])
      issue_cmd(directed_cmds[r].op, directed_cmds[r].val, directed_cmds[r].typed,
                directed_cmds[r].st);
    run_random_lists();
    start <= 1'b0;
    while (merge_beats_due.size() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
